FILE: design/protection_region_table_check_unit_defines.svh
// Assertion helpers shared by the protection region table check design.
`ifndef PROTECTION_REGION_TABLE_CHECK_UNIT_DEFINES_SVH
`define PROTECTION_REGION_TABLE_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRTC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("prtc: implication check failed");

// Next-cycle implication, checked outside reset.
`define PRTC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("prtc: next-cycle check failed");

`endif

FILE: design/prtc_pkg.sv
package prtc_pkg;

  localparam int NUM_REGIONS_DEF = 16;

  localparam logic [7:0] TEMP_PRIORITY = 8'd3;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_DISABLE = 3'd1,
    CMD_LOCK    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CHECK   = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_LOCKED  = 2'd3;

  localparam logic [2:0] PERM_R = 3'b001;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b100;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  perms;
    logic [7:0]  prio;
    logic        locked;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    start_addr: 32'd0,
    end_addr:   32'd0,
    perms:      3'd0,
    prio:       TEMP_PRIORITY,
    locked:     1'b0
  };

  typedef struct packed {
    logic hit;
    logic perm_ok;
  } cmp_res_t;

endpackage

FILE: design/prtc_region_mem.sv
module prtc_region_mem #(
  parameter int NUM_REGIONS = prtc_pkg::NUM_REGIONS_DEF,
  parameter int AW          = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  prtc_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output prtc_pkg::entry_t rdata
);
  import prtc_pkg::*;

  entry_t                 mem [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] valid_r;
  entry_t                 rdata_r;
  logic                   rvalid_r;

  // Valid bits stand in for the reset contents of the array.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r  <= mem[raddr];
    rvalid_r <= valid_r[raddr];
  end

  assign rdata = rvalid_r ? rdata_r : RESET_ENTRY;

endmodule

FILE: design/prtc_range_cmp.sv
module prtc_range_cmp (
  input  prtc_pkg::entry_t   entry,
  input  logic [31:0]        addr,
  input  logic [31:0]        last,
  input  logic [2:0]         need,
  output prtc_pkg::cmp_res_t res
);
  import prtc_pkg::*;

  logic enabled;

  // An entry with zero start and zero end is disabled.
  assign enabled     = (entry.start_addr != 32'd0) || (entry.end_addr != 32'd0);
  assign res.hit     = enabled && (entry.start_addr <= addr) && (last <= entry.end_addr);
  assign res.perm_ok = ((entry.perms & need) == need);

endmodule

FILE: design/protection_region_table_check_unit.sv
// Protection region table with access check. The block holds NUM_REGIONS
// regions (start inclusive, end exclusive, R/W/X permissions, priority tag,
// lock flag) in a register array with one write port and one registered
// read port, plus a high-water count of used entries. One item is handled at
// a time and in_ready is low until its result has been taken. Set, disable,
// lock and read fetch their entry at accept and go to S_TBL, where set,
// disable and lock write it back and the result is registered; commands
// that fail before the table is read (bad index, empty range, unknown
// command, overflowing access) present their result in the cycle after
// accept. A check scans entries 0 up to the used count in index order
// through one shared range comparator, one entry per cycle behind the read
// port, and stops early at the first matching entry. The table needs no
// clearing pass: per-entry valid bits make untouched entries read as their
// reset contents right after reset.
module protection_region_table_check_unit #(
  parameter int NUM_REGIONS = prtc_pkg::NUM_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_region_index,
  input  logic [31:0] in_range_start,
  input  logic [31:0] in_range_end,
  input  logic [2:0]  in_perm_bits,
  input  logic [7:0]  in_region_priority,
  input  logic        in_lock_on_set,
  input  logic [31:0] in_access_addr,
  input  logic [31:0] in_access_size,
  input  logic        in_write_access,
  input  logic        in_is_exec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_allowed,
  output logic [31:0] out_read_start,
  output logic [31:0] out_read_end,
  output logic [2:0]  out_read_perms,
  output logic [7:0]  out_read_priority,
  output logic        out_read_locked
);
  import prtc_pkg::*;
`include "protection_region_table_check_unit_defines.svh"

  localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CW = $clog2(NUM_REGIONS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TBL,
    S_SCAN,
    S_RESP
  } state_t;

  state_t      state_r;
  logic [2:0]  cmd_r;
  logic [AW-1:0] idx_r;
  logic [31:0] rs_r;
  logic [31:0] re_r;
  logic [2:0]  perm_r;
  logic [7:0]  prio_r;
  logic        lock_r;
  logic [31:0] addr_r;
  logic [31:0] last_r;
  logic [2:0]  need_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] scan_r;
  logic        pend_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_allowed_r;
  logic [31:0] out_read_start_r;
  logic [31:0] out_read_end_r;
  logic [2:0]  out_read_perms_r;
  logic [7:0]  out_read_priority_r;
  logic        out_read_locked_r;

  logic        in_fire;
  logic        idx_ok;
  logic [32:0] acc_sum;
  logic [2:0]  need_in;

  logic          mem_we;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        rd_entry;
  cmp_res_t      cmp;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign idx_ok   = ({1'b0, in_region_index} < 9'(NUM_REGIONS));
  assign acc_sum  = {1'b0, in_access_addr} + {1'b0, in_access_size};

  // Writes need W and fetches need X; a plain access needs R.
  always_comb begin
    need_in = 3'd0;
    if (in_write_access) begin
      need_in = need_in | PERM_W;
    end
    if (in_is_exec) begin
      need_in = need_in | PERM_X;
    end
    if (!in_write_access && !in_is_exec) begin
      need_in = PERM_R;
    end
  end

  // Read the addressed entry at accept; during a scan read the scan pointer.
  assign mem_raddr = (state_r == S_IDLE) ? in_region_index[AW-1:0] : scan_r[AW-1:0];

  prtc_region_mem #(
    .NUM_REGIONS (NUM_REGIONS),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  prtc_range_cmp u_cmp (
    .entry (rd_entry),
    .addr  (addr_r),
    .last  (last_r),
    .need  (need_r),
    .res   (cmp)
  );

  // Table update: set writes the whole entry, disable keeps priority and
  // lock, lock only raises the flag. Locked entries refuse set and disable.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_entry;
    if (state_r == S_TBL) begin
      unique case (cmd_r)
        CMD_SET: begin
          mem_we    = !rd_entry.locked;
          mem_wdata = '{start_addr: rs_r, end_addr: re_r, perms: perm_r,
                        prio: prio_r, locked: lock_r};
        end
        CMD_DISABLE: begin
          mem_we               = !rd_entry.locked;
          mem_wdata.start_addr = 32'd0;
          mem_wdata.end_addr   = 32'd0;
          mem_wdata.perms      = 3'd0;
        end
        CMD_LOCK: begin
          mem_we           = 1'b1;
          mem_wdata.locked = 1'b1;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r               <= in_cmd;
            idx_r               <= in_region_index[AW-1:0];
            rs_r                <= in_range_start;
            re_r                <= in_range_end;
            perm_r              <= in_perm_bits;
            prio_r              <= in_region_priority;
            lock_r              <= in_lock_on_set;
            addr_r              <= in_access_addr;
            last_r              <= acc_sum[31:0];
            need_r              <= need_in;
            scan_r              <= '0;
            pend_r              <= 1'b0;
            out_status_r        <= ST_OK;
            out_allowed_r       <= 1'b0;
            out_read_start_r    <= 32'd0;
            out_read_end_r      <= 32'd0;
            out_read_perms_r    <= 3'd0;
            out_read_priority_r <= 8'd0;
            out_read_locked_r   <= 1'b0;
            unique case (in_cmd)
              CMD_SET, CMD_DISABLE, CMD_LOCK, CMD_READ: begin
                if (!idx_ok) begin
                  out_status_r <= ST_INVALID;
                  out_valid_r  <= 1'b1;
                  state_r      <= S_RESP;
                end else if ((in_cmd == CMD_SET) && (in_range_start >= in_range_end)) begin
                  out_status_r <= ST_RANGE;
                  out_valid_r  <= 1'b1;
                  state_r      <= S_RESP;
                end else begin
                  state_r <= S_TBL;
                end
              end
              CMD_CHECK: begin
                // Deny an access that runs past the top of the address space.
                if (acc_sum[32]) begin
                  out_valid_r <= 1'b1;
                  state_r     <= S_RESP;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
                out_status_r <= ST_INVALID;
                out_valid_r  <= 1'b1;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_TBL: begin
          unique case (cmd_r)
            CMD_SET: begin
              if (rd_entry.locked) begin
                out_status_r <= ST_LOCKED;
              end else if (CW'(idx_r) >= used_r) begin
                used_r <= CW'(idx_r) + CW'(1);
              end
            end
            CMD_DISABLE: begin
              if (rd_entry.locked) begin
                out_status_r <= ST_LOCKED;
              end
            end
            CMD_READ: begin
              out_read_start_r    <= rd_entry.start_addr;
              out_read_end_r      <= rd_entry.end_addr;
              out_read_perms_r    <= rd_entry.perms;
              out_read_priority_r <= rd_entry.prio;
              out_read_locked_r   <= rd_entry.locked;
            end
            default: begin
              out_status_r <= ST_OK;
            end
          endcase
          out_valid_r <= 1'b1;
          state_r     <= S_RESP;
        end
        S_SCAN: begin
          // Compare the entry fetched last cycle while fetching the next one.
          if (pend_r && cmp.hit) begin
            out_allowed_r <= cmp.perm_ok;
            out_valid_r   <= 1'b1;
            state_r       <= S_RESP;
          end else if (scan_r == used_r) begin
            out_allowed_r <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_RESP;
          end else begin
            scan_r <= scan_r + CW'(1);
            pend_r <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_allowed       = out_allowed_r;
  assign out_read_start    = out_read_start_r;
  assign out_read_end      = out_read_end_r;
  assign out_read_perms    = out_read_perms_r;
  assign out_read_priority = out_read_priority_r;
  assign out_read_locked   = out_read_locked_r;

  `PRTC_ASSERT_IMP(a_one_side_busy, clk, rst_n, out_valid_r, !in_ready)
  `PRTC_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(NUM_REGIONS))
  `PRTC_ASSERT_IMP(a_no_locked_write, clk, rst_n,
                   mem_we && (cmd_r != CMD_LOCK), !rd_entry.locked)
  `PRTC_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == S_SCAN, scan_r <= used_r)
  `PRTC_ASSERT_IMP(a_allow_only_check, clk, rst_n,
                   out_valid_r && out_allowed_r, cmd_r == CMD_CHECK)
  `PRTC_ASSERT_NXT(a_resp_after_tbl, clk, rst_n, state_r == S_TBL, out_valid_r)

endmodule
